/* rtl/canrx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// canrx_pkg
// Shared types, codes and default sizes of the CAN receive queue store.
// ----------------------------------------------------------------------------
package canrx_pkg;

  // default sizes handed down from the top level
  localparam int unsigned BUS_COUNT_DEF     = 4;
  localparam int unsigned FIFO_DEPTH_DEF    = 16;
  localparam int unsigned SLOTS_PER_BUS_DEF = 16;

  localparam int unsigned ID_W     = 29;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned BUS_W    = 4;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  // register index, taken from paddr[2]
  localparam logic REG_BUS_ONLINE_MASK = 1'b0;

  typedef enum logic [2:0] {
    STAT_READ    = 3'd0,
    STAT_EMPTY   = 3'd1,
    STAT_OFFLINE = 3'd2,
    STAT_STORED  = 3'd3,
    STAT_FULL    = 3'd4,
    STAT_NOSLOT  = 3'd5
  } status_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BUS_W-1:0]  bus_index;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   out_id;
    logic [LEN_W-1:0]  out_length;
    logic [DATA_W-1:0] out_payload;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } frame_entry_t;

endpackage
`default_nettype wire

/* rtl/canrx_apb_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// canrx_apb_regs
// APB register file holding the bus online mask.
// ----------------------------------------------------------------------------
module canrx_apb_regs
  import canrx_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [MASK_W-1:0]  mask_o
);

  logic [MASK_W-1:0] mask_q;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign mask_o = mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (wr_en && (paddr[2] == REG_BUS_ONLINE_MASK)) begin
      mask_q <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BUS_ONLINE_MASK) begin
      prdata = {{(PDATA_W-MASK_W){1'b0}}, mask_q};
    end
  end

endmodule
`default_nettype wire

/* rtl/canrx_frame_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// canrx_frame_store
// Frame memory for all queues, one write and one registered read port.
// Bytes beyond the frame length are zeroed on the way in.
// ----------------------------------------------------------------------------
module canrx_frame_store
  import canrx_pkg::*;
#(
  parameter int unsigned DEPTH  = BUS_COUNT_DEF * SLOTS_PER_BUS_DEF * FIFO_DEPTH_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire frame_entry_t      wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output frame_entry_t           rdata_o
);

  frame_entry_t      mem_q [DEPTH];
  frame_entry_t      rdata_q;
  frame_entry_t      wr_entry;
  logic [DATA_W-1:0] byte_mask;

  always_comb begin
    for (int b = 0; b < DATA_W / 8; b++) begin
      byte_mask[b*8 +: 8] = (wdata_i.length > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    wr_entry.length = wdata_i.length;
    wr_entry.data   = wdata_i.data & byte_mask;
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wr_entry;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/canrx_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// canrx_seq
// Sequencer with the slot table: walks the claimed slots of a bus through
// one key comparator, then updates queue pointers and the frame store.
// ----------------------------------------------------------------------------
module canrx_seq
  import canrx_pkg::*;
#(
  parameter int unsigned BUS_COUNT     = BUS_COUNT_DEF,
  parameter int unsigned FIFO_DEPTH    = FIFO_DEPTH_DEF,
  parameter int unsigned SLOTS_PER_BUS = SLOTS_PER_BUS_DEF,
  parameter int unsigned FA_W          = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [MASK_W-1:0] mask_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  output logic                   fs_we_o,
  output logic      [FA_W-1:0]   fs_waddr_o,
  output frame_entry_t           fs_wdata_o,
  output logic                   fs_re_o,
  output logic      [FA_W-1:0]   fs_raddr_o,
  input  wire frame_entry_t      fs_rdata_i
);

  localparam int unsigned TOTAL = BUS_COUNT * SLOTS_PER_BUS;
  localparam int unsigned TS_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned S_W   = (SLOTS_PER_BUS > 1) ? $clog2(SLOTS_PER_BUS) : 1;
  localparam int unsigned F_W   = $clog2(SLOTS_PER_BUS + 1);
  localparam int unsigned C_W   = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned H_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned B_W   = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
  localparam int unsigned BUS_N = 2 ** BUS_W;

  localparam logic [BUS_W:0] BUS_LIM   = (BUS_W + 1)'(BUS_COUNT);
  localparam logic [C_W-1:0] DEPTH_C   = C_W'(FIFO_DEPTH);
  localparam logic [H_W:0]   DEPTH_H   = (H_W + 1)'(FIFO_DEPTH);
  localparam logic [H_W-1:0] HEAD_LAST = H_W'(FIFO_DEPTH - 1);
  localparam logic [F_W-1:0] SLOTS_F   = F_W'(SLOTS_PER_BUS);

  typedef struct packed {
    logic [ID_W-1:0] key;
    logic [C_W-1:0]  count;
    logic [H_W-1:0]  head;
  } slot_ent_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CHECK    = 7'b0000010,
    S_SRCH_RD  = 7'b0000100,
    S_SRCH_CMP = 7'b0001000,
    S_MISS     = 7'b0010000,
    S_FRD      = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  logic [TS_W-1:0]  base_q, base_d;
  logic [TS_W-1:0]  slot_q, slot_d;
  logic [FA_W-1:0]  fbase_q, fbase_d;
  logic [S_W-1:0]   s_q, s_d;
  logic [F_W-1:0]   fill_q [BUS_COUNT];
  logic [F_W-1:0]   fill_d [BUS_COUNT];
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // slot table memory
  slot_ent_t        slot_mem_q [TOTAL];
  slot_ent_t        slot_rd_q;
  logic             slot_we, slot_re;
  logic [TS_W-1:0]  slot_waddr, slot_raddr;
  slot_ent_t        slot_wdata;

  logic [BUS_N-1:0] mask_ext;
  logic             offline;
  logic [F_W-1:0]   fill_sel;
  logic             hit;
  logic [H_W:0]     psum;
  logic [H_W-1:0]   pos;
  logic [TS_W-1:0]  claim_slot;

  // buses without a mask bit read as offline
  assign mask_ext = {{(BUS_N - MASK_W){1'b0}}, mask_i};
  assign offline  = ({1'b0, item_q.bus_index} >= BUS_LIM) || !mask_ext[item_q.bus_index];
  assign fill_sel = fill_q[item_q.bus_index[B_W-1:0]];
  // the shared key comparator
  assign hit      = (slot_rd_q.key == item_q.frame_id);
  // append position, head + count is below twice the depth
  assign psum     = (H_W + 1)'(slot_rd_q.head) + (H_W + 1)'(slot_rd_q.count);
  assign pos      = (psum >= DEPTH_H) ? H_W'(psum - DEPTH_H) : H_W'(psum);
  assign claim_slot = base_q + TS_W'(fill_sel);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    base_d      = base_q;
    slot_d      = slot_q;
    fbase_d     = fbase_q;
    s_d         = s_q;
    fill_d      = fill_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    slot_waddr  = slot_q;
    slot_raddr  = base_q + TS_W'(s_q);
    slot_wdata  = '0;
    fs_we_o     = 1'b0;
    fs_waddr_o  = '0;
    fs_wdata_o  = '0;
    fs_re_o     = 1'b0;
    fs_raddr_o  = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.frame_length > MAX_LEN) begin
            item_d.frame_length = MAX_LEN;
          end
          base_d  = TS_W'(in_data_i.bus_index * SLOTS_PER_BUS);
          s_d     = '0;
          res_d   = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (offline) begin
          res_d.status = STAT_OFFLINE;
          state_d      = S_DONE;
        end else if (fill_sel == '0) begin
          state_d = S_MISS;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        slot_re = 1'b1;
        slot_d  = slot_raddr;
        fbase_d = FA_W'(slot_raddr * FIFO_DEPTH);
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (hit) begin
          if (item_q.op == OP_STORE) begin
            if (slot_rd_q.count >= DEPTH_C) begin
              res_d.status = STAT_FULL;
            end else begin
              fs_we_o           = 1'b1;
              fs_waddr_o        = fbase_q + FA_W'(pos);
              fs_wdata_o.length = item_q.frame_length;
              fs_wdata_o.data   = item_q.payload;
              slot_we           = 1'b1;
              slot_wdata        = slot_rd_q;
              slot_wdata.count  = slot_rd_q.count + C_W'(1);
              res_d.status      = STAT_STORED;
            end
            state_d = S_DONE;
          end else if (slot_rd_q.count == '0) begin
            res_d.status = STAT_EMPTY;
            state_d      = S_DONE;
          end else begin
            fs_re_o          = 1'b1;
            fs_raddr_o       = fbase_q + FA_W'(slot_rd_q.head);
            slot_we          = 1'b1;
            slot_wdata       = slot_rd_q;
            slot_wdata.count = slot_rd_q.count - C_W'(1);
            slot_wdata.head  = (slot_rd_q.head == HEAD_LAST) ? '0
                                                             : slot_rd_q.head + H_W'(1);
            res_d.status     = STAT_READ;
            res_d.out_id     = item_q.frame_id;
            state_d          = S_FRD;
          end
        end else if (F_W'(s_q) + F_W'(1) == fill_sel) begin
          state_d = S_MISS;
        end else begin
          s_d     = s_q + S_W'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_MISS: begin
        if (item_q.op == OP_READ) begin
          res_d.status = STAT_EMPTY;
        end else if (fill_sel < SLOTS_F) begin
          // claim the next free slot of this bus
          fs_we_o           = 1'b1;
          fs_waddr_o        = FA_W'(claim_slot * FIFO_DEPTH);
          fs_wdata_o.length = item_q.frame_length;
          fs_wdata_o.data   = item_q.payload;
          slot_we           = 1'b1;
          slot_waddr        = claim_slot;
          slot_wdata.key    = item_q.frame_id;
          slot_wdata.count  = C_W'(1);
          slot_wdata.head   = '0;
          fill_d[item_q.bus_index[B_W-1:0]] = fill_sel + F_W'(1);
          res_d.status      = STAT_STORED;
        end else begin
          res_d.status = STAT_NOSLOT;
        end
        state_d = S_DONE;
      end
      S_FRD: begin
        res_d.out_length  = fs_rdata_i.length;
        res_d.out_payload = fs_rdata_i.data;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      s_q         <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < BUS_COUNT; b++) begin
        fill_q[b] <= '0;
      end
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    base_q  <= base_d;
    slot_q  <= slot_d;
    fbase_q <= fbase_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem_q[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem_q[slot_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // compare only sees slot data read in the cycle before
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SRCH_CMP |-> $past(state_q) == S_SRCH_RD)
    else $error("slot compare without a slot read");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> slot_wdata.count <= DEPTH_C)
    else $error("queue count beyond depth");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done state");

  a_frame_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_re_o |=> state_q == S_FRD && res_q.status == STAT_READ)
    else $error("frame read not followed by result capture");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && !offline) |-> fill_sel <= SLOTS_F)
    else $error("slot fill count beyond slots per bus");

endmodule
`default_nettype wire

/* rtl/can_rx_per_id_fifo_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// can_rx_per_id_fifo_store
// CAN receive buffer with one frame queue per identifier on each bus.
// ----------------------------------------------------------------------------
// One item is in work at a time. From the accepting cycle the sequencer
// enters the check state and goes straight to the done state for an offline
// bus; otherwise each claimed slot compared takes a read and a compare state,
// and a read hit adds the frame read state and a miss the miss state, before
// the done state loads the result into the output register, waiting while
// that register holds an unaccepted result. The linear key search runs
// through the single slot table port, each slot read, then compared. Slots
// of a bus are claimed in order and never freed, so a per-bus fill count
// marks the claimed slots and no clearing pass runs after reset.
// A finished result sits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
module can_rx_per_id_fifo_store
  import canrx_pkg::*;
#(
  parameter int unsigned BUS_COUNT     = BUS_COUNT_DEF,
  parameter int unsigned FIFO_DEPTH    = FIFO_DEPTH_DEF,
  parameter int unsigned SLOTS_PER_BUS = SLOTS_PER_BUS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_data_o
);

  localparam int unsigned FS_DEPTH = BUS_COUNT * SLOTS_PER_BUS * FIFO_DEPTH;
  localparam int unsigned FA_W     = (FS_DEPTH > 1) ? $clog2(FS_DEPTH) : 1;

  logic [MASK_W-1:0] mask;
  logic              fs_we, fs_re;
  logic [FA_W-1:0]   fs_waddr, fs_raddr;
  frame_entry_t      fs_wdata, fs_rdata;

  canrx_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mask_o  (mask)
  );

  canrx_seq #(
    .BUS_COUNT     (BUS_COUNT),
    .FIFO_DEPTH    (FIFO_DEPTH),
    .SLOTS_PER_BUS (SLOTS_PER_BUS),
    .FA_W          (FA_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mask_i      (mask),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .fs_we_o     (fs_we),
    .fs_waddr_o  (fs_waddr),
    .fs_wdata_o  (fs_wdata),
    .fs_re_o     (fs_re),
    .fs_raddr_o  (fs_raddr),
    .fs_rdata_i  (fs_rdata)
  );

  canrx_frame_store #(
    .DEPTH  (FS_DEPTH),
    .ADDR_W (FA_W)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (fs_re),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the per-identifier CAN receive queue store against a cycle-free
// model of its slot table and frame queues. Items are pushed through the
// valid/ready input with random gaps, results are compared field by field in
// arrival order, and the bus online mask is changed over the APB port between
// traffic phases.
// ----------------------------------------------------------------------------
module testbench;
  import canrx_pkg::*;

  localparam int unsigned NUM_SLOTS  = BUS_COUNT_DEF * SLOTS_PER_BUS_DEF;
  localparam int unsigned NUM_FRAMES = NUM_SLOTS * FIFO_DEPTH_DEF;
  localparam int unsigned POOL_SIZE  = 20;
  localparam int unsigned MAX_GAP    = 13;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [PADDR_W-1:0] ONLINE_MASK_ADDR = {REG_BUS_ONLINE_MASK, 2'b00};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;

  // model of the buffer contents
  logic [MASK_W-1:0] online_mask;
  bit                slot_used   [NUM_SLOTS];
  logic [ID_W-1:0]   slot_id     [NUM_SLOTS];
  int unsigned       slot_fill   [NUM_SLOTS];
  int unsigned       slot_rd_ptr [NUM_SLOTS];
  logic [LEN_W-1:0]  stored_len  [NUM_FRAMES];
  logic [DATA_W-1:0] stored_data [NUM_FRAMES];

  out_item_t         pending_responses[$];
  logic [ID_W-1:0]   id_pool [BUS_COUNT_DEF][POOL_SIZE];

  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_hold_left;
  int unsigned failures;
  int unsigned items_sent;
  int unsigned mask_writes;
  int unsigned status_seen [8];

  can_rx_per_id_fifo_store #(
    .BUS_COUNT     (BUS_COUNT_DEF),
    .FIFO_DEPTH    (FIFO_DEPTH_DEF),
    .SLOTS_PER_BUS (SLOTS_PER_BUS_DEF)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // works out the result of one accepted item and updates the model
  function automatic out_item_t rx_buffer_response(in_item_t it);
    out_item_t         r;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] keep;
    int                slot;
    int unsigned       base;
    int unsigned       pos;
    r = '0;
    slot = -1;
    len = (it.frame_length > MAX_LEN) ? MAX_LEN : it.frame_length;
    keep = (len >= MAX_LEN) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
    if (it.bus_index >= BUS_COUNT_DEF || !online_mask[it.bus_index]) begin
      r.status = STAT_OFFLINE;
    end else begin
      base = it.bus_index * SLOTS_PER_BUS_DEF;
      for (int s = 0; s < SLOTS_PER_BUS_DEF; s++) begin
        if (slot < 0 && slot_used[base+s] && slot_id[base+s] == it.frame_id) slot = base + s;
      end
      if (it.op == OP_STORE) begin
        // first sighting of an identifier claims the lowest free slot
        for (int s = 0; s < SLOTS_PER_BUS_DEF; s++) begin
          if (slot < 0 && !slot_used[base+s]) begin
            slot = base + s;
            slot_used[slot] = 1'b1;
            slot_id[slot] = it.frame_id;
            slot_fill[slot] = 0;
            slot_rd_ptr[slot] = 0;
          end
        end
        if (slot < 0) begin
          r.status = STAT_NOSLOT;
        end else if (slot_fill[slot] >= FIFO_DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          pos = slot * FIFO_DEPTH_DEF + (slot_rd_ptr[slot] + slot_fill[slot]) % FIFO_DEPTH_DEF;
          stored_len[pos] = len;
          stored_data[pos] = it.payload & keep;
          slot_fill[slot]++;
          r.status = STAT_STORED;
        end
      end else begin
        if (slot < 0 || slot_fill[slot] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          pos = slot * FIFO_DEPTH_DEF + slot_rd_ptr[slot];
          r.status = STAT_READ;
          r.out_id = it.frame_id;
          r.out_length = stored_len[pos];
          r.out_payload = stored_data[pos];
          slot_rd_ptr[slot] = (slot_rd_ptr[slot] + 1) % FIFO_DEPTH_DEF;
          slot_fill[slot]--;
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_item(op_e op, logic [BUS_W-1:0] bus, logic [ID_W-1:0] id,
                                         logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
    in_item_t it;
    it.op = op;
    it.bus_index = bus;
    it.frame_id = id;
    it.frame_length = len;
    it.payload = data;
    return it;
  endfunction

  task automatic check_response(out_item_t got);
    out_item_t want;
    if (pending_responses.size() == 0) begin
      $error("result without a pending item: status %0d id %0h", got.status, got.out_id);
      failures++;
      return;
    end
    want = pending_responses.pop_front();
    status_seen[int'(want.status)]++;
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
    if (got.out_id !== want.out_id) begin
      $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
      failures++;
    end
    if (got.out_length !== want.out_length) begin
      $error("out_length: expected %0d, got %0d", want.out_length, got.out_length);
      failures++;
    end
    if (got.out_payload !== want.out_payload) begin
      $error("out_payload: expected %0h, got %0h", want.out_payload, got.out_payload);
      failures++;
    end
  endtask

  // result side: random stalls after each transfer, plus long hold-offs on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        check_response(out_data_o);
        stall_left = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_frame_item(in_item_t it);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pending_responses.push_back(rx_buffer_response(it));
    items_sent++;
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_responses.size() != 0);
  endtask

  // write the mask while idle, then read it back
  task automatic write_online_mask(logic [MASK_W-1:0] m);
    drain_responses();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ONLINE_MASK_ADDR;
    pwdata <= PDATA_W'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    online_mask = m;
    mask_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[MASK_W-1:0] !== m) begin
      $error("bus_online_mask: expected %0h, got %0h", m, prdata[MASK_W-1:0]);
      failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_offline_buses();
    send_frame_item(make_item(OP_STORE, 4'd0, 29'h123, 4'd8, {$urandom, $urandom}));
    send_frame_item(make_item(OP_READ, 4'd1, 29'h123, 4'd0, '0));
    write_online_mask('1);
    // bus numbers past the bus count are never online
    send_frame_item(make_item(OP_STORE, 4'd4, 29'h7FF, 4'd15, '1));
    send_frame_item(make_item(OP_READ, 4'd15, ID_MAX, 4'd8, '1));
  endtask

  task automatic test_store_read_extremes();
    send_frame_item(make_item(OP_STORE, 4'd0, ID_MAX, 4'd15, '1));
    send_frame_item(make_item(OP_STORE, 4'd0, ID_MAX, 4'd0, '1));
    send_frame_item(make_item(OP_STORE, 4'd0, ID_MAX, 4'd3, {$urandom, $urandom}));
    send_frame_item(make_item(OP_STORE, 4'd0, '0, 4'd8, {$urandom, $urandom}));
    repeat (4) send_frame_item(make_item(OP_READ, 4'd0, ID_MAX, 4'd0, '0));
    send_frame_item(make_item(OP_READ, 4'd0, '0, 4'd15, '1));
    // identifier never stored: no slot gets claimed
    send_frame_item(make_item(OP_READ, 4'd0, 29'h0ABCDEF0, 4'd8, '1));
  endtask

  task automatic test_slot_exhaustion();
    // two slots of bus 0 are already taken by the extremes test
    for (int k = 2; k <= SLOTS_PER_BUS_DEF; k++) begin
      send_frame_item(make_item(OP_STORE, 4'd0, id_pool[0][k], LEN_W'($urandom_range(0, 15)),
                                {$urandom, $urandom}));
    end
  endtask

  task automatic test_output_backpressure();
    drain_responses();
    tx_steady = 1'b1;
    rx_hold_left = HOLD_CYCLES;
    // more stores than the queue holds, while results back up
    repeat (FIFO_DEPTH_DEF + 2) begin
      send_frame_item(make_item(OP_STORE, 4'd1, id_pool[1][0], LEN_W'($urandom_range(0, 15)),
                                {$urandom, $urandom}));
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    drain_responses();
    repeat (FIFO_DEPTH_DEF + 1) begin
      send_frame_item(make_item(OP_READ, 4'd1, id_pool[1][0], LEN_W'($urandom_range(0, 15)),
                                {$urandom, $urandom}));
    end
  endtask

  task automatic test_random_traffic();
    logic [MASK_W-1:0] phase_masks [7];
    logic [BUS_W-1:0]  bus;
    logic [ID_W-1:0]   id;
    int unsigned       counted;
    int unsigned       burst;
    int unsigned       store_pct;
    op_e               op;
    phase_masks = '{4'hF, 4'h5, 4'hA, 4'h0, 4'h1, 4'h8, 4'hF};
    phase_masks[3] = MASK_W'($urandom_range(1, 15));
    for (int p = 0; p < 7; p++) begin
      write_online_mask(phase_masks[p]);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 2);
      store_pct = (p % 2 == 0) ? 70 : 45;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          bus = BUS_W'($urandom_range(0, 15));
        end else begin
          do bus = BUS_W'($urandom_range(0, BUS_COUNT_DEF - 1)); while (!online_mask[bus]);
        end
        if (bus >= BUS_COUNT_DEF || $urandom_range(0, 9) == 0) id = ID_W'($urandom);
        else id = id_pool[bus][$urandom_range(0, POOL_SIZE - 1)];
        // occasional long runs on one identifier push queues to full and back
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 4);
        repeat (burst) begin
          op = ($urandom_range(0, 99) < store_pct) ? OP_STORE : OP_READ;
          send_frame_item(make_item(op, bus, id, LEN_W'($urandom_range(0, 15)),
                                    {$urandom, $urandom}));
          if (bus < BUS_COUNT_DEF && online_mask[bus]) counted++;
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    int unsigned guard;
    logic [ID_W-1:0] cand;
    bit dup;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold_left = 0;
    failures = 0;
    items_sent = 0;
    mask_writes = 0;
    online_mask = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_id[i] = '0;
      slot_fill[i] = 0;
      slot_rd_ptr[i] = 0;
    end
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    // distinct identifiers per bus, a mix of standard and extended ones
    for (int b = 0; b < BUS_COUNT_DEF; b++) begin
      for (int k = 0; k < POOL_SIZE; k++) begin
        do begin
          cand = (k % 2 == 0) ? ID_W'($urandom_range(0, 2047)) : ID_W'($urandom);
          if (b == 0 && k == 0) cand = ID_MAX;
          if (b == 0 && k == 1) cand = '0;
          dup = (b == 0 && k > 1 && (cand == ID_MAX || cand == '0 || cand == 29'h0ABCDEF0));
          for (int j = 0; j < k; j++) if (id_pool[b][j] == cand) dup = 1'b1;
        end while (dup);
        id_pool[b][k] = cand;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_offline_buses();
    test_store_read_extremes();
    test_slot_exhaustion();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic();

    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_responses.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * SLOTS_PER_BUS_DEF + 8) @(posedge clk_i);
    if (pending_responses.size() != 0) begin
      $error("%0d results never arrived", pending_responses.size());
      failures += pending_responses.size();
    end
    $display("Sent %0d frames over %0d mask settings: read %0d, empty %0d, offline %0d,",
             items_sent, mask_writes, status_seen[STAT_READ], status_seen[STAT_EMPTY],
             status_seen[STAT_OFFLINE]);
    $display("stored %0d, dropped on full queue %0d, dropped with no slot %0d; %0d errors",
             status_seen[STAT_STORED], status_seen[STAT_FULL], status_seen[STAT_NOSLOT],
             failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
